// ===== src/gnav_pkg.sv =====
// shared types, codes and helper functions for the gamepad navigation block
package gnav_pkg;

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_PRESS   = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;
	localparam logic [1:0] CMD_RESUME  = 2'd3;

	localparam logic [1:0] CFG_SWAP    = 2'd0;
	localparam logic [1:0] CFG_UI_NAV  = 2'd1;
	localparam logic [1:0] CFG_ACT_THR = 2'd2;
	localparam logic [1:0] CFG_REL_THR = 2'd3;

	localparam logic [14:0] ACT_THR_RESET = 15'd20000;
	localparam logic [14:0] REL_THR_RESET = 15'd16000;

	localparam logic [2:0] DIR_NONE  = 3'd0;
	localparam logic [2:0] DIR_UP    = 3'd1;
	localparam logic [2:0] DIR_DOWN  = 3'd2;
	localparam logic [2:0] DIR_LEFT  = 3'd3;
	localparam logic [2:0] DIR_RIGHT = 3'd4;

	localparam logic [3:0] BTN_A      = 4'd0;
	localparam logic [3:0] BTN_B      = 4'd1;
	localparam logic [3:0] BTN_X      = 4'd2;
	localparam logic [3:0] BTN_Y      = 4'd3;
	localparam logic [3:0] BTN_START  = 4'd4;
	localparam logic [3:0] BTN_LSHLD  = 4'd5;
	localparam logic [3:0] BTN_RSHLD  = 4'd6;
	localparam logic [3:0] BTN_DUP    = 4'd7;
	localparam logic [3:0] BTN_DDOWN  = 4'd8;
	localparam logic [3:0] BTN_DLEFT  = 4'd9;
	localparam logic [3:0] BTN_DRIGHT = 4'd10;
	localparam logic [3:0] BTN_OTHER  = 4'd11;

	localparam logic [3:0] KC_UP       = 4'd0;
	localparam logic [3:0] KC_DOWN     = 4'd1;
	localparam logic [3:0] KC_LEFT     = 4'd2;
	localparam logic [3:0] KC_RIGHT    = 4'd3;
	localparam logic [3:0] KC_TAB      = 4'd4;
	localparam logic [3:0] KC_BACKTAB  = 4'd5;
	localparam logic [3:0] KC_SPACE    = 4'd6;
	localparam logic [3:0] KC_RETURN   = 4'd7;
	localparam logic [3:0] KC_ESCAPE   = 4'd8;
	localparam logic [3:0] KC_MENU     = 4'd9;
	localparam logic [3:0] KC_SETTINGS = 4'd10;
	localparam logic [3:0] KC_PGUP     = 4'd11;
	localparam logic [3:0] KC_PGDN     = 4'd12;

	localparam logic [31:0] HOLD_SHORT = 32'd400;
	localparam logic [31:0] HOLD_LONG  = 32'd1600;
	localparam logic [8:0]  DELAY_SLOW = 9'd400;
	localparam logic [8:0]  DELAY_MID  = 9'd150;
	localparam logic [8:0]  DELAY_FAST = 9'd75;

	typedef struct packed {
		logic       valid;
		logic [3:0] key;
		logic       press;
		logic       flush;
	} gnav_emit_t;

	typedef struct packed {
		logic rdy;
		logic pend_v;
	} gnav_ostat_t;

	typedef struct packed {
		logic        load;
		logic [31:0] now;
		logic [31:0] t;
	} gnav_unit_req_t;

	function automatic logic [3:0] dir_key(input logic [2:0] dir, input logic ui);
		logic [3:0] k;
		k = KC_RIGHT;
		unique case (dir)
			DIR_UP:   k = ui ? KC_BACKTAB : KC_UP;
			DIR_DOWN: k = ui ? KC_TAB : KC_DOWN;
			DIR_LEFT: k = KC_LEFT;
			default:  k = KC_RIGHT;
		endcase
		return k;
	endfunction

	function automatic logic [8:0] repeat_delay(input logic [31:0] held);
		logic [8:0] d;
		if (held < HOLD_SHORT) d = DELAY_SLOW;
		else if (held < HOLD_LONG) d = DELAY_MID;
		else d = DELAY_FAST;
		return d;
	endfunction

endpackage

// ===== src/gnav_time_unit.sv =====
// shared time unit: one wrapping subtractor, hold register and repeat compare
module gnav_time_unit
	import gnav_pkg::*;
(
	input  logic           clk,
	input  gnav_unit_req_t req,
	output logic           due
);

	logic [31:0] diff;
	logic [31:0] hold_q;

	assign diff = req.now - req.t;
	assign due  = diff >= {23'd0, repeat_delay(hold_q)};

	always_ff @(posedge clk) begin
		if (req.load) begin
			hold_q <= diff;
		end
	end

endmodule

// ===== src/gnav_out.sv =====
// result staging: one pending item and the output register, marks the last item
module gnav_out
	import gnav_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  gnav_emit_t  emit,
	output gnav_ostat_t ostat,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  key,
	output logic        is_press,
	output logic        last
);

	logic       out_v_q;
	logic [3:0] out_key_q;
	logic       out_press_q;
	logic       out_last_q;
	logic       pend_v_q;
	logic [3:0] pend_key_q;
	logic       pend_press_q;
	logic       out_free;
	logic       rdy;
	logic       push;
	logic       take_emit;

	assign out_free  = !out_v_q || !out_stall;
	assign rdy       = !pend_v_q || out_free;
	assign take_emit = emit.valid && rdy;
	assign push      = pend_v_q && out_free && (emit.valid || emit.flush);

	assign ostat.rdy    = rdy;
	assign ostat.pend_v = pend_v_q;

	assign out_valid = out_v_q;
	assign key       = out_key_q;
	assign is_press  = out_press_q;
	assign last      = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (push) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			if (take_emit) begin
				pend_v_q <= 1'b1;
			end else if (push) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_key_q   <= pend_key_q;
			out_press_q <= pend_press_q;
			out_last_q  <= !emit.valid;
		end
		if (take_emit) begin
			pend_key_q   <= emit.key;
			pend_press_q <= emit.press;
		end
	end

endmodule

// ===== src/gnav_ctrl.sv =====
// sequencer: config registers, stick and d-pad state, channel walk per item
module gnav_ctrl
	import gnav_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [31:0]         now_ms,
	input  logic signed [15:0]  stick_x,
	input  logic signed [15:0]  stick_y,
	input  logic [3:0]          button,
	input  logic [3:0]          dpad_mask,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [14:0]         cfg_data,
	output gnav_unit_req_t      ureq,
	input  logic                due,
	output gnav_emit_t          emit,
	input  gnav_ostat_t         ostat
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_STICK  = 4'd1;
	localparam logic [3:0] ST_HELD   = 4'd2;
	localparam logic [3:0] ST_CHECK  = 4'd3;
	localparam logic [3:0] ST_PRESS  = 4'd4;
	localparam logic [3:0] ST_REL    = 4'd5;
	localparam logic [3:0] ST_BUTTON = 4'd6;
	localparam logic [3:0] ST_RESUME = 4'd7;
	localparam logic [3:0] ST_FLUSH  = 4'd8;

	localparam logic [2:0] CH_STICK = 3'd0;
	localparam logic [2:0] CH_FIRST = 3'd1;
	localparam logic [2:0] CH_LAST  = 3'd4;

	logic [3:0]  st_q;
	logic [2:0]  ch_q;
	logic [2:0]  sdir_q;
	logic [3:0]  dpad_held_q;
	logic        swap_q;
	logic        ui_q;
	logic [14:0] act_q;
	logic [14:0] rel_q;

	logic [1:0]         cmd_q;
	logic [31:0]        now_q;
	logic signed [15:0] x_q;
	logic signed [15:0] y_q;
	logic [3:0]         button_q;
	logic [3:0]         mask_q;
	logic [31:0]        since_q [0:4];
	logic [31:0]        fire_q [0:4];

	logic               accept;
	logic [1:0]         dch;
	logic [2:0]         cur_dir;
	logic [2:0]         dir_new;
	logic               kept;
	logic signed [16:0] x17;
	logic signed [16:0] y17;
	logic signed [16:0] act17;
	logic signed [16:0] rel17;
	logic [3:0]         bsel;
	logic               btn_emit;
	logic [3:0]         btn_key;
	logic               btn_dpad;
	logic [1:0]         btn_d;
	logic [3:0]         bsub;
	logic               btn_go;
	logic [4:0]         since_we;
	logic [4:0]         fire_we;
	logic [31:0]        stamp;

	assign accept    = (st_q == ST_IDLE) && in_valid;
	assign in_stall  = st_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign dch       = 2'(ch_q - CH_FIRST);
	assign cur_dir   = (ch_q == CH_STICK) ? sdir_q : ch_q;
	assign stamp     = (st_q == ST_IDLE) ? now_ms : now_q;

	// stick direction with hysteresis
	always_comb begin
		x17   = {x_q[15], x_q};
		y17   = {y_q[15], y_q};
		act17 = {2'b00, act_q};
		rel17 = {2'b00, rel_q};
		kept  = 1'b0;
		unique case (sdir_q)
			DIR_NONE:  kept = 1'b0;
			DIR_UP:    kept = y17 < -rel17;
			DIR_DOWN:  kept = y17 > rel17;
			DIR_LEFT:  kept = x17 < -rel17;
			default:   kept = x17 > rel17;
		endcase
		if (kept) dir_new = sdir_q;
		else if (y17 < -act17) dir_new = DIR_UP;
		else if (y17 > act17) dir_new = DIR_DOWN;
		else if (x17 < -act17) dir_new = DIR_LEFT;
		else if (x17 > act17) dir_new = DIR_RIGHT;
		else dir_new = DIR_NONE;
	end

	// button decode
	always_comb begin
		bsel     = (swap_q && button_q < BTN_START) ? (button_q ^ 4'd1) : button_q;
		bsub     = bsel - BTN_DUP;
		btn_d    = bsub[1:0];
		btn_dpad = 1'b0;
		btn_emit = 1'b1;
		btn_key  = KC_SETTINGS;
		unique case (bsel)
			BTN_A:      btn_key = ui_q ? KC_SPACE : KC_RETURN;
			BTN_B:      btn_key = KC_ESCAPE;
			BTN_X:      btn_key = KC_MENU;
			BTN_Y, BTN_START: btn_key = KC_SETTINGS;
			BTN_LSHLD: begin
				btn_key  = KC_PGUP;
				btn_emit = ui_q;
			end
			BTN_RSHLD: begin
				btn_key  = KC_PGDN;
				btn_emit = ui_q;
			end
			BTN_DUP, BTN_DDOWN, BTN_DLEFT, BTN_DRIGHT: begin
				btn_dpad = 1'b1;
				btn_key  = dir_key(3'({1'b0, btn_d}) + 3'd1, ui_q);
			end
			default:    btn_emit = 1'b0;
		endcase
		btn_go = !btn_emit || ostat.rdy;
	end

	// shared unit request and result emission
	always_comb begin
		ureq.load = st_q == ST_HELD;
		ureq.now  = now_q;
		ureq.t    = (st_q == ST_HELD) ? since_q[ch_q] : fire_q[ch_q];
		emit      = '0;
		unique case (st_q)
			ST_PRESS: begin
				emit.valid = 1'b1;
				emit.key   = dir_key(cur_dir, ui_q);
				emit.press = 1'b1;
			end
			ST_REL: begin
				emit.valid = 1'b1;
				emit.key   = dir_key(cur_dir, ui_q);
			end
			ST_BUTTON: begin
				emit.valid = btn_emit;
				emit.key   = btn_key;
				emit.press = cmd_q == CMD_PRESS;
			end
			ST_RESUME: begin
				emit.valid = mask_q[dch];
				emit.key   = dir_key(ch_q, ui_q);
				emit.press = 1'b1;
			end
			ST_FLUSH:  emit.flush = 1'b1;
			default:   emit = '0;
		endcase
	end

	// time stamp write enables
	always_comb begin
		since_we = '0;
		fire_we  = '0;
		if (accept && cmd == CMD_RESUME) begin
			since_we = {dpad_mask, 1'b0};
			fire_we  = {dpad_mask, 1'b0};
		end
		unique case (st_q)
			ST_STICK: begin
				since_we[0] = dir_new != sdir_q;
				fire_we[0]  = (dir_new != sdir_q) && (dir_new != DIR_NONE);
			end
			ST_CHECK: fire_we[ch_q] = due;
			ST_BUTTON: begin
				if (btn_dpad && cmd_q == CMD_PRESS && btn_go) begin
					since_we[3'({1'b0, btn_d}) + 3'd1] = 1'b1;
					fire_we[3'({1'b0, btn_d}) + 3'd1]  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			now_q    <= now_ms;
			x_q      <= stick_x;
			y_q      <= stick_y;
			button_q <= button;
			mask_q   <= dpad_mask;
		end
		for (int i = 0; i < 5; i++) begin
			if (since_we[i]) since_q[i] <= stamp;
			if (fire_we[i]) fire_q[i] <= stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ch_q        <= CH_STICK;
			sdir_q      <= DIR_NONE;
			dpad_held_q <= '0;
			swap_q      <= 1'b0;
			ui_q        <= 1'b0;
			act_q       <= ACT_THR_RESET;
			rel_q       <= REL_THR_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SWAP:    swap_q <= cfg_data[0];
					CFG_UI_NAV:  ui_q   <= cfg_data[0];
					CFG_ACT_THR: act_q  <= cfg_data;
					CFG_REL_THR: rel_q  <= cfg_data;
				endcase
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (cmd)
							CMD_TICK: begin
								ch_q <= CH_STICK;
								st_q <= ST_STICK;
							end
							CMD_PRESS, CMD_RELEASE: st_q <= ST_BUTTON;
							CMD_RESUME: begin
								sdir_q      <= DIR_NONE;
								dpad_held_q <= dpad_mask;
								ch_q        <= CH_FIRST;
								st_q        <= ST_RESUME;
							end
						endcase
					end
				end
				ST_STICK: begin
					if (dir_new != sdir_q) begin
						sdir_q <= dir_new;
						if (dir_new != DIR_NONE) begin
							st_q <= ST_PRESS;
						end else begin
							ch_q <= CH_FIRST;
							st_q <= ST_HELD;
						end
					end else begin
						if (dir_new == DIR_NONE) ch_q <= CH_FIRST;
						st_q <= ST_HELD;
					end
				end
				ST_HELD: begin
					if (ch_q != CH_STICK && !dpad_held_q[dch]) begin
						if (ch_q == CH_LAST) st_q <= ST_FLUSH;
						else ch_q <= ch_q + 3'd1;
					end else begin
						st_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (due) begin
						st_q <= ST_PRESS;
					end else if (ch_q == CH_LAST) begin
						st_q <= ST_FLUSH;
					end else begin
						ch_q <= ch_q + 3'd1;
						st_q <= ST_HELD;
					end
				end
				ST_PRESS: begin
					if (ostat.rdy) st_q <= ST_REL;
				end
				ST_REL: begin
					if (ostat.rdy) begin
						if (ch_q == CH_LAST) begin
							st_q <= ST_FLUSH;
						end else begin
							ch_q <= ch_q + 3'd1;
							st_q <= ST_HELD;
						end
					end
				end
				ST_BUTTON: begin
					if (btn_go) begin
						if (btn_dpad) dpad_held_q[btn_d] <= cmd_q == CMD_PRESS;
						st_q <= ST_FLUSH;
					end
				end
				ST_RESUME: begin
					if (!mask_q[dch] || ostat.rdy) begin
						if (ch_q == CH_LAST) st_q <= ST_FLUSH;
						else ch_q <= ch_q + 3'd1;
					end
				end
				ST_FLUSH: begin
					if (ostat.rdy) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/gamepad_nav_autorepeat_top.sv =====
// top level of the gamepad navigation key generator with autorepeat
//
// input channel: in_valid/in_stall with cmd, now_ms, stick_x, stick_y, button,
// dpad_mask; an item is taken when in_valid is high and in_stall is low.
// output channel: out_valid/out_stall with key, is_press, last; last marks
// the final result of an item. an item with no result produces nothing.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, write
// only while no item is in flight.
// items are handled one at a time by a sequencer that walks the stick and
// the four d-pad channels through one shared subtract and compare unit.
// a tick checks the stick and each held d-pad channel and emits a press and
// a release for each direction that fires; a resume presses each masked
// channel. the sequencer waits only while the output side stalls.
// one result is held back in a pending stage so last can be set; it moves
// to the output register when the next result is made or the item ends.
// a stalled output stops the sequencer, nothing is lost.
// reset clears the stick direction, the held d-pad flags and the output and
// pending valid flags, and loads the config registers with their defaults.
module gamepad_nav_autorepeat_top
	import gnav_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [31:0]        now_ms,
	input  logic signed [15:0] stick_x,
	input  logic signed [15:0] stick_y,
	input  logic [3:0]         button,
	input  logic [3:0]         dpad_mask,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         key,
	output logic               is_press,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data
);

	gnav_unit_req_t ureq;
	logic           due;
	gnav_emit_t     emit;
	gnav_ostat_t    ostat;

	gnav_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.now_ms    (now_ms),
		.stick_x   (stick_x),
		.stick_y   (stick_y),
		.button    (button),
		.dpad_mask (dpad_mask),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ureq      (ureq),
		.due       (due),
		.emit      (emit),
		.ostat     (ostat)
	);

	gnav_time_unit u_time (
		.clk (clk),
		.req (ureq),
		.due (due)
	);

	gnav_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.ostat     (ostat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.key       (key),
		.is_press  (is_press),
		.last      (last)
	);

endmodule
